// ===== rtl/sync_length_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length frame receiver
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/slfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slfr_pkg
// Types, codes and constants of the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

    localparam int unsigned MAX_FRAME = 128;

    localparam logic [7:0]  SYNC_FIRST       = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND      = 8'hFF;
    localparam logic [8:0]  FRAME_OVERHEAD   = 9'd9;
    localparam logic [15:0] GAP_RESET        = 16'd1000;
    localparam logic [7:0]  POS_STATION      = 8'd4;
    localparam logic [7:0]  POS_LENGTH       = 8'd5;
    localparam logic [7:0]  STATION_FAIL_LEN = 8'd5;

    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SECOND  = 2'd1,
        PH_COLLECT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        V_ACCEPT   = 2'd0,
        V_STATION  = 2'd1,
        V_SHORT    = 2'd2,
        V_OVERFLOW = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATION_ID = 1'b0,
        CFG_GAP_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [6:0] position;
        logic [1:0] verdict;
        logic [7:0] frame_length;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  station_id;
        logic [15:0] gap_limit;
    } t_cfg;

endpackage

// ===== rtl/slfr_cfg.sv =====
// ----------------------------------------------------------------------------
// slfr_cfg
// Configuration registers: station number and inter-byte gap limit.
// ----------------------------------------------------------------------------
module slfr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [slfr_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [31:0]                       i_wr_data,
    output slfr_pkg::t_cfg                    o_cfg
);
    import slfr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_STATION_ID: n_cfg.station_id = i_wr_data[7:0];
                CFG_GAP_LIMIT:  n_cfg.gap_limit  = i_wr_data[15:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.station_id <= 8'd0;
            r_cfg.gap_limit  <= GAP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/slfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// slfr_ctrl
// Frame state machine: sync hunt, byte collection, gap timing and verdicts.
// ----------------------------------------------------------------------------
module slfr_ctrl #(
    parameter int unsigned P_MAX_FRAME = slfr_pkg::MAX_FRAME
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  slfr_pkg::t_in_item   i_item,
    input  slfr_pkg::t_cfg       i_cfg,
    output logic                 o_res_valid,
    output slfr_pkg::t_out_item  o_result
);
    import slfr_pkg::*;

    localparam logic [7:0] MAX_COUNT = 8'(P_MAX_FRAME);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_body,  n_body;
    logic [15:0] r_gap,   n_gap;

    logic        is_byte;
    logic        is_tick;
    logic [15:0] gap_inc;
    logic        gap_end;
    logic [8:0]  need;
    logic        frame_full;
    logic        station_bad;

    assign is_byte     = i_step && (i_item.opcode == OP_BYTE);
    assign is_tick     = i_step && (i_item.opcode == OP_TICK);
    assign gap_inc     = (r_gap == 16'hFFFF) ? r_gap : r_gap + 16'd1;
    assign gap_end     = (gap_inc >= i_cfg.gap_limit);
    assign need        = {1'b0, r_body} + FRAME_OVERHEAD;
    assign frame_full  = (r_count >= MAX_COUNT);
    assign station_bad = (r_count == POS_STATION) && (i_item.rx_byte != i_cfg.station_id);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SECOND: begin
                if (is_byte) begin
                    n_phase = (i_item.rx_byte == SYNC_SECOND) ? PH_COLLECT : PH_HUNT;
                end
            end
            PH_COLLECT: begin
                if (is_tick && gap_end) begin
                    n_phase = PH_HUNT;
                end else if (is_byte && (frame_full || station_bad)) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                // The spare phase code is treated as hunting.
                if (is_byte && (i_item.rx_byte == SYNC_FIRST)) begin
                    n_phase = PH_SECOND;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Counters and result.
    always_comb begin
        n_count     = r_count;
        n_body      = r_body;
        n_gap       = r_gap;
        o_res_valid = 1'b0;
        o_result    = '0;
        unique case (r_phase)
            PH_SECOND: begin
                if (is_byte) begin
                    n_count = (i_item.rx_byte == SYNC_SECOND) ? 8'd2 : 8'd0;
                    n_body  = 8'd0;
                    n_gap   = 16'd0;
                end
            end
            PH_COLLECT: begin
                if (is_tick) begin
                    n_gap = gap_inc;
                    if (gap_end) begin
                        o_res_valid           = 1'b1;
                        o_result.kind         = KIND_VERDICT;
                        o_result.verdict      = ({1'b0, r_count} >= need) ? V_ACCEPT : V_SHORT;
                        o_result.frame_length = r_count;
                        n_count = 8'd0;
                        n_body  = 8'd0;
                        n_gap   = 16'd0;
                    end
                end else if (is_byte) begin
                    if (frame_full) begin
                        o_res_valid           = 1'b1;
                        o_result.kind         = KIND_VERDICT;
                        o_result.verdict      = V_OVERFLOW;
                        o_result.frame_length = MAX_COUNT;
                        n_count = 8'd0;
                        n_body  = 8'd0;
                        n_gap   = 16'd0;
                    end else if (station_bad) begin
                        o_res_valid           = 1'b1;
                        o_result.kind         = KIND_VERDICT;
                        o_result.verdict      = V_STATION;
                        o_result.frame_length = STATION_FAIL_LEN;
                        n_count = 8'd0;
                        n_body  = 8'd0;
                        n_gap   = 16'd0;
                    end else begin
                        n_gap   = 16'd0;
                        n_count = r_count + 8'd1;
                        if (r_count == POS_LENGTH) begin
                            n_body = i_item.rx_byte;
                        end
                        o_res_valid       = 1'b1;
                        o_result.kind     = KIND_BYTE;
                        o_result.data     = i_item.rx_byte;
                        o_result.position = r_count[6:0];
                    end
                end
            end
            default: begin
                if (is_byte && (i_item.rx_byte == SYNC_FIRST)) begin
                    n_count = 8'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= 8'd0;
            r_body  <= 8'd0;
            r_gap   <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_body  <= n_body;
            r_gap   <= n_gap;
        end
    end

endmodule

// ===== rtl/sync_length_frame_receiver.sv =====
// A request is captured in the input register, and its result is presented from the result register.
// Throughput: one request per cycle, set by the input register and result register
// around the combinational frame logic; a stalled result holds back one request.
// Reset (synchronous, active low) returns the receiver to sync hunting, empties
// both registers and loads station_id 0 and gap_limit 1000.
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Receives serial bytes and timer ticks, finds sync-framed packets, reports
// each collected byte with its position and an end-of-frame verdict.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver #(
    parameter int unsigned P_MAX_FRAME = slfr_pkg::MAX_FRAME
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  slfr_pkg::t_in_item                i_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output slfr_pkg::t_out_item               o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [slfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import slfr_pkg::*;
    `include "sync_length_frame_receiver_macros.svh"

    t_cfg      cfg;
    logic      advance;
    logic      res_valid;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_cfg_ready = 1'b1;

    slfr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The pipeline moves whenever the result register is empty or being taken.
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;

    slfr_ctrl #(
        .P_MAX_FRAME (P_MAX_FRAME)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_in_valid && advance),
        .i_item      (r_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // An empty input register takes a request even while the result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_item <= i_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_item;

    `SLFR_ASSERT_SAME(a_stall_only_when_full, o_stall, r_in_valid && r_out_valid && i_stall,
        "input stalled while the result register could move")
    `SLFR_ASSERT_SAME(a_byte_position, o_valid && (o_result.kind == KIND_BYTE),
        (o_result.position >= 7'd2) && (o_result.frame_length == 8'd0),
        "byte result with a sync position or a frame length")
    `SLFR_ASSERT_SAME(a_verdict_fields, o_valid && (o_result.kind == KIND_VERDICT),
        (o_result.data == 8'd0) && (o_result.position == 7'd0)
        && (o_result.frame_length <= 8'(P_MAX_FRAME)),
        "verdict result carries byte fields or an oversized frame length")
    `SLFR_ASSERT_NEXT(a_no_result_from_nothing, !r_in_valid && advance, !o_valid,
        "result produced without a request in the input register")

endmodule
